### hw/rtl/psxp_pkg.sv
// psxp_pkg: transaction types and fixed protocol constants for the pad slave
// no dependencies; used by psxp_engine and psx_digital_pad_slave_core
package psxp_pkg;

	typedef struct packed {
		logic [1:0]  kind;
		logic        cmd_bit;
		logic [12:0] buttons;
	} in_t;

	typedef struct packed {
		logic data_out;
		logic data_enable;
		logic ack_pulse;
		logic byte_done;
	} out_t;

	localparam logic [1:0] KIND_ATT_FALL = 2'd0;
	localparam logic [1:0] KIND_CLK_FALL = 2'd1;
	localparam logic [1:0] KIND_CLK_RISE = 2'd2;
	localparam logic [1:0] KIND_ATT_RISE = 2'd3;

	localparam logic [7:0] CMD_START   = 8'h01;
	localparam logic [7:0] CMD_POLL    = 8'h42;
	localparam logic [7:0] ID_RESET    = 8'h41;
	localparam logic [7:0] REPLY_READY = 8'h5A;
	localparam logic [7:0] BYTE_IDLE   = 8'hFF;
	localparam logic [7:0] BYTE_ZERO   = 8'h00;

endpackage

### hw/rtl/psx_digital_pad_slave_core.sv
// psx_digital_pad_slave_core: top level, edge event in, pad response out
// result register with a skid stage; depends on psxp_pkg and psxp_engine
// accepted event's result goes to result register, or skid stage if stalled
// throughput: one event per cycle, limited only by the two-entry result buffer
// in_ready drops only when both result register and skid stage are full
// reset: idle, id byte 0x41, reply byte 0xff, button bytes all released
module psx_digital_pad_slave_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  psxp_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output psxp_pkg::out_t  out_data,
	input  logic            cfg_we,
	input  logic [7:0]      cfg_data
);

	psxp_pkg::out_t result;
	psxp_pkg::out_t out_q, skid_q;
	logic           out_valid_q, skid_valid_q;
	logic           push;

	assign in_ready  = ~skid_valid_q;
	assign push      = in_valid & in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	psxp_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (push),
		.item     (in_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q  <= skid_valid_q | push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_q <= skid_valid_q ? skid_q : result;
		end else if (push) begin
			skid_q <= result;
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid stage full with empty result register");

	a_skid_drains_first: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && out_ready |=> out_valid_q && !skid_valid_q
			&& out_q == $past(skid_q))
		else $error("skid transaction not moved to result register");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> out_valid_q)
		else $error("accepted transaction lost");

endmodule

### hw/rtl/psxp_engine.sv
// psxp_engine: serial link state, shift registers and header check
// computes one result per accepted edge event; depends on psxp_pkg
module psxp_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  psxp_pkg::in_t   item,
	input  logic            cfg_we,
	input  logic [7:0]      cfg_data,
	output psxp_pkg::out_t  result
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_B0,
		PH_B1,
		PH_B2,
		PH_B3,
		PH_B4,
		PH_DRAIN
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [2:0] bit_count_q, bit_count_d;
	logic [7:0] tx_shift_q, tx_shift_d;
	logic [7:0] rx_shift_q, rx_shift_d;
	logic [7:0] pad_low_q, pad_low_d;
	logic [7:0] pad_high_q, pad_high_d;
	logic [7:0] id_byte_q;
	logic [7:0] rx_next;
	logic       data_out, ack, done;

	assign rx_next = {item.cmd_bit, rx_shift_q[7:1]};

	always_comb begin
		phase_d     = phase_q;
		bit_count_d = bit_count_q;
		tx_shift_d  = tx_shift_q;
		rx_shift_d  = rx_shift_q;
		pad_low_d   = pad_low_q;
		pad_high_d  = pad_high_q;
		data_out    = 1'b1;
		ack         = 1'b0;
		done        = 1'b0;
		if (item.kind == psxp_pkg::KIND_ATT_FALL) begin
			// active-low button bytes, unused bits held high
			pad_low_d   = {~item.buttons[5], ~item.buttons[4], ~item.buttons[3],
				~item.buttons[2], ~item.buttons[1], 1'b1, 1'b1, ~item.buttons[0]};
			pad_high_d  = {~item.buttons[12], ~item.buttons[11], ~item.buttons[10],
				~item.buttons[9], 1'b1, ~item.buttons[8], ~item.buttons[7],
				~item.buttons[6]};
			phase_d     = PH_B0;
			bit_count_d = '0;
			tx_shift_d  = psxp_pkg::BYTE_IDLE;
			rx_shift_d  = '0;
		end else if (item.kind == psxp_pkg::KIND_ATT_RISE) begin
			phase_d     = PH_IDLE;
			bit_count_d = '0;
			tx_shift_d  = psxp_pkg::BYTE_IDLE;
			rx_shift_d  = '0;
		end else if (phase_q != PH_IDLE) begin
			if (item.kind == psxp_pkg::KIND_CLK_FALL) begin
				data_out   = tx_shift_q[0];
				tx_shift_d = {1'b0, tx_shift_q[7:1]};
			end else begin
				rx_shift_d  = rx_next;
				bit_count_d = bit_count_q + 3'd1;
				if (bit_count_q == 3'd7) begin
					done = 1'b1;
					ack  = 1'b1;
					case (phase_q)
						PH_B0: begin
							if (rx_next == psxp_pkg::CMD_START) begin
								tx_shift_d = id_byte_q;
								phase_d    = PH_B1;
							end else begin
								ack        = 1'b0;
								tx_shift_d = psxp_pkg::BYTE_ZERO;
								phase_d    = PH_DRAIN;
							end
						end
						PH_B1: begin
							if (rx_next == psxp_pkg::CMD_POLL) begin
								tx_shift_d = psxp_pkg::REPLY_READY;
								phase_d    = PH_B2;
							end else begin
								ack        = 1'b0;
								tx_shift_d = psxp_pkg::BYTE_ZERO;
								phase_d    = PH_DRAIN;
							end
						end
						PH_B2: begin
							tx_shift_d = pad_low_q;
							phase_d    = PH_B3;
						end
						PH_B3: begin
							tx_shift_d = pad_high_q;
							phase_d    = PH_B4;
						end
						default: begin
							tx_shift_d = psxp_pkg::BYTE_ZERO;
							phase_d    = PH_DRAIN;
						end
					endcase
				end
			end
		end
	end

	assign result.data_out    = data_out;
	assign result.data_enable = (phase_d != PH_IDLE);
	assign result.ack_pulse   = ack;
	assign result.byte_done   = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_count_q <= '0;
			tx_shift_q  <= psxp_pkg::BYTE_IDLE;
			rx_shift_q  <= '0;
			pad_low_q   <= psxp_pkg::BYTE_IDLE;
			pad_high_q  <= psxp_pkg::BYTE_IDLE;
		end else if (accept) begin
			phase_q     <= phase_d;
			bit_count_q <= bit_count_d;
			tx_shift_q  <= tx_shift_d;
			rx_shift_q  <= rx_shift_d;
			pad_low_q   <= pad_low_d;
			pad_high_q  <= pad_high_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_byte_q <= psxp_pkg::ID_RESET;
		end else if (cfg_we) begin
			id_byte_q <= cfg_data;
		end
	end

	// idle means a clean exchange context
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> bit_count_q == 3'd0 && rx_shift_q == 8'h00
			&& tx_shift_q == psxp_pkg::BYTE_IDLE)
		else $error("idle with stale shift state");

	a_att_fall: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.kind == psxp_pkg::KIND_ATT_FALL |=> phase_q == PH_B0
			&& bit_count_q == 3'd0)
		else $error("attention fall did not restart exchange");

	a_done_on_eighth: assert property (@(posedge clk) disable iff (!arst_n)
		accept && result.byte_done |-> item.kind == psxp_pkg::KIND_CLK_RISE
			&& bit_count_q == 3'd7 && result.data_enable)
		else $error("byte completed off the eighth rise");

endmodule
